// ----- rtl/core/rsti_pkg.sv -----
`timescale 1ns / 1ps

package rsti_pkg;

	// Alphabet storage: sixteen byte-wide symbols across two 64-bit registers.
	localparam int SYM_COUNT      = 16;
	localparam int SYM_W          = 8;
	localparam int RADIX_W        = 5;
	localparam int DIGIT_W        = 4;
	localparam int MAX_SYMBOLS    = 16;
	localparam int VALUE_BITS_DEF = 32;

	// Character classes.
	localparam logic [SYM_W-1:0] SYM_MIN   = 8'd33;
	localparam logic [SYM_W-1:0] SYM_MAX   = 8'd126;
	localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [SYM_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [SYM_W-1:0] CH_WS_LO  = 8'd9;
	localparam logic [SYM_W-1:0] CH_WS_HI  = 8'd13;

	// Register indexes (byte address is 8 times the index).
	localparam logic [1:0] REG_RADIX    = 2'd0;
	localparam logic [1:0] REG_ALPHA_LO = 2'd1;
	localparam logic [1:0] REG_ALPHA_HI = 2'd2;

	typedef struct packed {
		logic [RADIX_W-1:0]                radix;
		logic [SYM_COUNT-1:0][SYM_W-1:0]   symbols;
	} cfg_t;

endpackage

// ----- rtl/core/rsti_alpha_check.sv -----
`timescale 1ns / 1ps

// Checks the configured alphabet: radix in range, every symbol in use is
// printable and not a sign, and no two symbols in use are equal.
module rsti_alpha_check import rsti_pkg::*; (
	input  cfg_t cfg,
	output logic ok
);

	logic bad;

	always_comb begin
		bad = (cfg.radix < RADIX_W'(2)) || (cfg.radix > RADIX_W'(MAX_SYMBOLS));
		for (int i = 0; i < SYM_COUNT; i++) begin
			if (RADIX_W'(i) < cfg.radix) begin
				if (cfg.symbols[i] < SYM_MIN || cfg.symbols[i] > SYM_MAX ||
				    cfg.symbols[i] == CH_PLUS || cfg.symbols[i] == CH_MINUS) begin
					bad = 1'b1;
				end
				for (int j = i + 1; j < SYM_COUNT; j++) begin
					if (RADIX_W'(j) < cfg.radix && cfg.symbols[j] == cfg.symbols[i]) begin
						bad = 1'b1;
					end
				end
			end
		end
		ok = !bad;
	end

endmodule

// ----- rtl/core/radix_string_to_integer.sv -----
`timescale 1ns / 1ps

// Radix string to integer converter. Characters arrive one byte per slave
// transaction; the transaction with tlast set ends the string and produces one
// master transaction carrying the signed result in tdata and the alphabet
// status in tuser. Leading whitespace (space and codes 9 to 13) is skipped, a
// run of '+' and '-' signs follows with each '-' flipping the sign, and then
// digits of the configured alphabet accumulate as value times radix plus
// digit index, wrapping modulo 2^VALUE_BITS and sign-extended or truncated
// to 32 bits. The first other character ends the parse for that string. When
// the alphabet is invalid the result is 0 with tuser low. The block accepts
// one character per clock cycle unless an end transaction in the input
// register waits on a result that is not taken. A result passes through the
// input register and then the single-pass stage that does the digit lookup
// and the multiply-add. A result that is not taken holds back the next end
// transaction and the characters behind it; characters ahead of it keep
// flowing. Alphabet status is recomputed the cycle after a configuration write.
module radix_string_to_integer import rsti_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port (APB style)
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// Character stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // is_end
	// Result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic [0:0]  m_tuser    // [0] alphabet_ok
);

	typedef enum logic [1:0] {PH_SPACE, PH_SIGN, PH_DIGIT, PH_STOP} phase_t;

	// Configuration registers.
	logic [RADIX_W-1:0] radix_q;
	logic [63:0]        alpha_lo_q;
	logic [63:0]        alpha_hi_q;
	logic               ok_q;
	cfg_t               cfg;
	logic               ok_comb;
	logic               cfg_wr;

	// Input register.
	logic               vld_s1;
	logic [SYM_W-1:0]   ch_s1;
	logic               end_s1;

	// Parse state.
	phase_t                 phase_q;
	logic                   neg_q;
	logic [VALUE_BITS-1:0]  acc_q;

	// Result register.
	logic        m_vld_q;
	logic [31:0] value_q;
	logic        res_ok_q;

	logic                   adv_s1;
	logic                   is_ws;
	logic                   is_sign;
	logic                   hit;
	logic [DIGIT_W-1:0]     digit;
	logic [VALUE_BITS+4:0]  prod;
	logic [VALUE_BITS-1:0]  acc_next;
	logic signed [VALUE_BITS-1:0] signed_val;
	logic signed [63:0]     wide_val;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[4:3])
			REG_RADIX:    prdata = {{(64-RADIX_W){1'b0}}, radix_q};
			REG_ALPHA_LO: prdata = alpha_lo_q;
			REG_ALPHA_HI: prdata = alpha_hi_q;
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= '0;
			alpha_lo_q <= '0;
			alpha_hi_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				REG_RADIX:    radix_q    <= pwdata[RADIX_W-1:0];
				REG_ALPHA_LO: alpha_lo_q <= pwdata;
				REG_ALPHA_HI: alpha_hi_q <= pwdata;
				default: ;
			endcase
		end
	end

	assign cfg.radix   = radix_q;
	assign cfg.symbols = {alpha_hi_q, alpha_lo_q};

	rsti_alpha_check u_alpha_check (
		.cfg (cfg),
		.ok  (ok_comb)
	);

	// The validity check is wide, so its answer is registered. A reset
	// alphabet has radix 0 and is invalid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else begin
			ok_q <= ok_comb;
		end
	end

	// Only an end transaction needs the result register; ordinary characters
	// always leave the input register.
	assign adv_s1   = !end_s1 || !m_vld_q || m_tready;
	assign s_tready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1  <= s_tdata;
			end_s1 <= s_tlast;
		end
	end

	// Character classification and digit lookup. The lowest matching symbol
	// position below the radix wins.
	always_comb begin
		is_ws   = ch_s1 inside {CH_SPACE, [CH_WS_LO:CH_WS_HI]};
		is_sign = (ch_s1 == CH_PLUS) || (ch_s1 == CH_MINUS);
		hit     = 1'b0;
		digit   = '0;
		for (int k = SYM_COUNT - 1; k >= 0; k--) begin
			if (RADIX_W'(k) < radix_q && cfg.symbols[k] == ch_s1) begin
				hit   = 1'b1;
				digit = DIGIT_W'(k);
			end
		end
	end

	assign prod     = (VALUE_BITS+5)'(acc_q) * (VALUE_BITS+5)'(radix_q);
	assign acc_next = prod[VALUE_BITS-1:0] + VALUE_BITS'(digit);

	assign signed_val = neg_q ? (VALUE_BITS'(0) - acc_q) : acc_q;
	assign wide_val   = 64'(signed_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SPACE;
			neg_q    <= 1'b0;
			acc_q    <= '0;
			m_vld_q  <= 1'b0;
			value_q  <= '0;
			res_ok_q <= 1'b0;
		end else begin
			// A new result may replace the one being taken in the same cycle.
			if (vld_s1 && adv_s1 && end_s1) begin
				m_vld_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
			if (vld_s1 && adv_s1) begin
				if (end_s1) begin
					value_q  <= ok_q ? wide_val[31:0] : 32'd0;
					res_ok_q <= ok_q;
					phase_q  <= PH_SPACE;
					neg_q    <= 1'b0;
					acc_q    <= '0;
				end else if (phase_q == PH_SPACE && is_ws) begin
					phase_q <= PH_SPACE;
				end else if ((phase_q == PH_SPACE || phase_q == PH_SIGN) && is_sign) begin
					if (ch_s1 == CH_MINUS) begin
						neg_q <= !neg_q;
					end
					phase_q <= PH_SIGN;
				end else if (phase_q != PH_STOP) begin
					if (hit) begin
						acc_q   <= acc_next;
						phase_q <= PH_DIGIT;
					end else begin
						phase_q <= PH_STOP;
					end
				end
			end
		end
	end

	assign m_tvalid   = m_vld_q;
	assign m_tdata    = value_q;
	assign m_tuser[0] = res_ok_q;

endmodule

// ----- rtl/core/rsti_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks for the radix string to integer converter.
module rsti_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An invalid alphabet always reports zero.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
		else $error("nonzero value with invalid alphabet");

	// A fresh result follows an accepted end transaction.
	a_res_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result without end transaction");

	// With no result waiting the input is never stalled.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

endmodule

bind radix_string_to_integer rsti_checker u_rsti_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- dv/radix_string_to_integer_checker.sv -----
`timescale 1ns / 1ps

// Watches the configuration port and both streams, keeps its own parse of the
// character stream and compares every result transaction with the oldest
// predicted one.
module radix_string_to_integer_checker import rsti_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // is_end
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] value
	input  logic [0:0]  m_tuser,   // [0] alphabet_ok
	input  logic        wrap_up,
	output int          failures,
	output int          results_seen
);

	typedef enum logic [1:0] {SKIP_SPACE, TAKE_SIGNS, TAKE_DIGITS, STOPPED} parse_state_t;

	typedef struct packed {
		logic [31:0] value;
		logic        alphabet_ok;
	} parsed_int_t;

	cfg_t         alphabet;
	parse_state_t state;
	logic         negative;
	logic [31:0]  accumulator;
	parsed_int_t  parsed_ints[$];
	parsed_int_t  oldest;
	bit           wrapped;

	function automatic logic alphabet_usable(cfg_t c);
		if (c.radix < 2 || c.radix > MAX_SYMBOLS)
			return 1'b0;
		for (int i = 0; i < c.radix; i++) begin
			if (c.symbols[i] < SYM_MIN || c.symbols[i] > SYM_MAX ||
					c.symbols[i] == CH_PLUS || c.symbols[i] == CH_MINUS)
				return 1'b0;
			for (int j = i + 1; j < c.radix; j++)
				if (c.symbols[j] == c.symbols[i])
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Position of the character in the alphabet, or -1 when it is no digit.
	function automatic int digit_value(cfg_t c, logic [7:0] ch);
		for (int k = 0; k < SYM_COUNT && k < c.radix; k++)
			if (c.symbols[k] == ch)
				return k;
		return -1;
	endfunction

	task automatic advance_parse(input logic [7:0] ch);
		int d;
		if (state == SKIP_SPACE && (ch == CH_SPACE || (ch >= CH_WS_LO && ch <= CH_WS_HI)))
			return;
		if ((state == SKIP_SPACE || state == TAKE_SIGNS) && (ch == CH_PLUS || ch == CH_MINUS)) begin
			if (ch == CH_MINUS)
				negative = !negative;
			state = TAKE_SIGNS;
			return;
		end
		if (state != STOPPED) begin
			d = digit_value(alphabet, ch);
			if (d >= 0) begin
				accumulator = accumulator * 32'(alphabet.radix) + 32'(d);
				state = TAKE_DIGITS;
			end else begin
				state = STOPPED;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet = '0;
			state = SKIP_SPACE;
			negative = 1'b0;
			accumulator = '0;
			parsed_ints.delete();
			failures = 0;
			wrapped = 1'b0;
			results_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_RADIX:    alphabet.radix = pwdata[RADIX_W-1:0];
					REG_ALPHA_LO: alphabet.symbols[7:0] = pwdata;
					REG_ALPHA_HI: alphabet.symbols[15:8] = pwdata;
					default: ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				if (parsed_ints.size() == 0) begin
					$error("result with no string pending: value %0d, alphabet_ok %0b",
						$signed(m_tdata), m_tuser[0]);
					failures++;
				end else begin
					oldest = parsed_ints.pop_front();
					if (m_tdata !== oldest.value) begin
						$error("value: expected %0d, actual %0d",
							$signed(oldest.value), $signed(m_tdata));
						failures++;
					end
					if (m_tuser[0] !== oldest.alphabet_ok) begin
						$error("alphabet_ok: expected %0b, actual %0b",
							oldest.alphabet_ok, m_tuser[0]);
						failures++;
					end
				end
				results_seen <= results_seen + 1;
			end

			if (s_tvalid && s_tready) begin
				if (s_tlast) begin
					oldest.alphabet_ok = alphabet_usable(alphabet);
					oldest.value = !oldest.alphabet_ok ? 32'd0 :
						negative ? -accumulator : accumulator;
					parsed_ints.push_back(oldest);
					state = SKIP_SPACE;
					negative = 1'b0;
					accumulator = '0;
				end else begin
					advance_parse(s_tdata);
				end
			end

			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (parsed_ints.size() != 0) begin
					$error("%0d strings ended without a result", parsed_ints.size());
					failures += parsed_ints.size();
				end
			end
		end
	end

endmodule

// ----- dv/radix_string_to_integer_test.sv -----
`timescale 1ns / 1ps

module radix_string_to_integer_test;
	import rsti_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 4;
	// Wait after the last result so that any trailing characters clear the input
	// register and parse stage.
	localparam int DRAIN_CYCLES = 6;
	// Cycles without any transaction before the run is declared hung.
	localparam int STALL_LIMIT  = 2000;
	// Minimum characters per alphabet setting, end transactions included.
	localparam int PHASE_CHARS  = 110;

	// The register map has room for a fourth register; writes there must be
	// ignored by the block.
	localparam logic [1:0] REG_SPARE = 2'd3;

	// Kinds of alphabet setting the run walks through.
	typedef enum int {
		KIND_DECIMAL,
		KIND_HEX,
		KIND_EDGE_BINARY,   // two symbols at the printable extremes
		KIND_RANDOM_VALID,
		KIND_RADIX_ONE,
		KIND_RADIX_OVER,    // radix above the symbol count
		KIND_DUPLICATE,
		KIND_SIGN_SYMBOL,   // a '+' or '-' inside the alphabet
		KIND_NONPRINT,      // a symbol outside the printable range
		KIND_ZERO,          // all registers back to their reset values
		KIND_ALL_ONES,
		KIND_RAW            // fully random register contents
	} alphabet_kind_t;

	localparam int PLAN_LEN = 15;
	// Each third of the plan runs under one idling mode and mixes valid and
	// invalid alphabets.
	localparam alphabet_kind_t PLAN [PLAN_LEN] = '{
		KIND_DECIMAL, KIND_HEX, KIND_RANDOM_VALID, KIND_RADIX_ONE, KIND_DUPLICATE,
		KIND_EDGE_BINARY, KIND_RADIX_OVER, KIND_RANDOM_VALID, KIND_SIGN_SYMBOL, KIND_NONPRINT,
		KIND_RAW, KIND_ZERO, KIND_ALL_ONES, KIND_RANDOM_VALID, KIND_RAW
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [7:0] ch
	logic        s_tlast = 1'b0;  // is_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] value
	logic [0:0]  m_tuser;         // [0] alphabet_ok
	logic        wrap_up = 1'b0;

	int failures;
	int results_seen;

	// Percentages of cycles in which the sender holds back and the receiver
	// refuses a result; changed per third of the plan.
	int send_idle_pct = 20;
	int recv_idle_pct = 82;

	int chars_sent = 0;
	int strings_sent = 0;
	int stalled_cycles = 0;
	int phase_start;

	// Stimulus-side copy of the alphabet, used only to pick digit characters.
	cfg_t alphabet = '0;
	logic [7:0] text_q[$];

	radix_string_to_integer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	radix_string_to_integer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.wrap_up      (wrap_up),
		.failures     (failures),
		.results_seen (results_seen)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// The receiver draws a fresh ready every cycle, so its stalls land on
	// every phase of the block's output handshake.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	// Watchdog: any accepted transaction on either stream or the configuration
	// port restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pwrite && pready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles + 1 >= STALL_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	// Offers one character transaction and waits until it is taken. The valid
	// stays high afterward so that back-to-back transactions never lower and
	// raise it in the same step; it only drops at the start of an idle gap.
	task automatic send_item(input logic [7:0] ch, input logic last);
		if ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		chars_sent++;
	endtask

	// Sends the characters in text_q and then the end transaction, whose
	// character byte is random since the block must ignore it.
	task automatic send_string();
		foreach (text_q[i])
			send_item(text_q[i], 1'b0);
		send_item(8'($urandom), 1'b1);
		strings_sent++;
	endtask

	// Builds one random string in text_q. Most strings are well formed:
	// whitespace, a run of signs, digits from the current alphabet and now and
	// then trailing junk. Some are pure noise, and some are well formed with
	// one character swapped for a space, a sign or a random byte so that the
	// parse stops in an unusual place.
	task automatic build_string();
		int roll;
		int count;
		int pick;
		int symbols_in_use;
		text_q.delete();
		roll = $urandom_range(99, 0);
		symbols_in_use = (alphabet.radix > SYM_COUNT) ? SYM_COUNT : alphabet.radix;
		if (roll < 10) begin
			count = $urandom_range(8, 0);
			repeat (count) text_q.push_back(8'($urandom));
			return;
		end
		repeat ($urandom_range(3, 0))
			text_q.push_back(($urandom_range(5, 0) == 0) ? CH_SPACE :
				8'($urandom_range(CH_WS_HI, CH_WS_LO)));
		repeat ($urandom_range(3, 0))
			text_q.push_back(($urandom_range(1, 0) != 0) ? CH_MINUS : CH_PLUS);
		// Long digit runs can overflow and wrap; short ones stay in range.
		count = ($urandom_range(3, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 0);
		if (symbols_in_use > 0)
			repeat (count)
				text_q.push_back(alphabet.symbols[$urandom_range(symbols_in_use - 1, 0)]);
		if ($urandom_range(2, 0) == 0)
			repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom));
		if (roll < 25 && text_q.size() > 0) begin
			pick = $urandom_range(text_q.size() - 1, 0);
			case ($urandom_range(3, 0))
				0: text_q[pick] = CH_SPACE;
				1: text_q[pick] = CH_PLUS;
				2: text_q[pick] = CH_MINUS;
				default: text_q[pick] = 8'($urandom);
			endcase
		end
	endtask

	// Alphabet of count distinct printable symbols other than the signs; the
	// bytes past the radix are random and may repeat digits, which the block
	// must ignore.
	function automatic cfg_t random_alphabet(int count);
		cfg_t c;
		logic [7:0] sym;
		bit clash;
		c.radix = RADIX_W'(count);
		for (int k = 0; k < SYM_COUNT; k++)
			c.symbols[k] = 8'($urandom);
		for (int k = 0; k < count; k++) begin
			do begin
				sym = 8'($urandom_range(SYM_MAX, SYM_MIN));
				clash = (sym == CH_PLUS) || (sym == CH_MINUS);
				for (int j = 0; j < k; j++)
					if (c.symbols[j] == sym)
						clash = 1'b1;
			end while (clash);
			c.symbols[k] = sym;
		end
		return c;
	endfunction

	// One APB write. The select is left high so that a following write starts
	// its setup cycle without a drop in the same step.
	task automatic write_reg(input logic [1:0] reg_index, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_index, 3'b000};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Waits until the block is idle, then writes the radix and both symbol registers
	// for the requested kind of alphabet, and the spare register for raw contents.
	task automatic apply_setting(input alphabet_kind_t kind);
		cfg_t c;
		string digits;
		int first;
		int second;
		case (kind)
			KIND_DECIMAL, KIND_HEX: begin
				digits = (kind == KIND_DECIMAL) ? "0123456789" : "0123456789abcdef";
				c = random_alphabet(digits.len());
				for (int k = 0; k < digits.len(); k++)
					c.symbols[k] = digits[k];
			end
			KIND_EDGE_BINARY: begin
				c = random_alphabet(2);
				c.symbols[0] = SYM_MIN;
				c.symbols[1] = SYM_MAX;
			end
			KIND_RANDOM_VALID: c = random_alphabet($urandom_range(SYM_COUNT, 2));
			KIND_RADIX_ONE: c = random_alphabet(1);
			KIND_RADIX_OVER: begin
				c = random_alphabet(SYM_COUNT);
				c.radix = RADIX_W'($urandom_range(30, MAX_SYMBOLS + 1));
			end
			KIND_DUPLICATE: begin
				c = random_alphabet($urandom_range(SYM_COUNT, 2));
				first = $urandom_range(c.radix - 2, 0);
				second = $urandom_range(c.radix - 1, first + 1);
				c.symbols[second] = c.symbols[first];
			end
			KIND_SIGN_SYMBOL: begin
				c = random_alphabet($urandom_range(SYM_COUNT, 2));
				c.symbols[$urandom_range(c.radix - 1, 0)] =
					($urandom_range(1, 0) != 0) ? CH_PLUS : CH_MINUS;
			end
			KIND_NONPRINT: begin
				// Just below or above the printable range; the low side can also
				// put whitespace or the zero byte into the alphabet.
				c = random_alphabet($urandom_range(SYM_COUNT, 2));
				c.symbols[$urandom_range(c.radix - 1, 0)] = ($urandom_range(1, 0) != 0) ?
					8'($urandom_range(SYM_MIN - 1, 0)) : 8'($urandom_range(255, SYM_MAX + 1));
			end
			KIND_ZERO: c = '0;
			KIND_ALL_ONES: c = '1;
			default: begin
				c.radix = RADIX_W'($urandom);
				c.symbols = {$urandom, $urandom, $urandom, $urandom};
			end
		endcase

		while (results_seen != strings_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_RADIX, 64'(c.radix));
		write_reg(REG_ALPHA_LO, c.symbols[7:0]);
		write_reg(REG_ALPHA_HI, c.symbols[15:8]);
		if (kind == KIND_RAW)
			write_reg(REG_SPARE, {$urandom, $urandom});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		alphabet = c;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PLAN_LEN; p++) begin
			// Sender idles now and then while the receiver stalls most of the time,
			// then the roles swap, and the last third runs at full rate.
			if (p < PLAN_LEN / 3) begin
				send_idle_pct = 20;
				recv_idle_pct = 82;
			end else if (p < 2 * PLAN_LEN / 3) begin
				send_idle_pct = 82;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			apply_setting(PLAN[p]);
			phase_start = chars_sent;

			// Directed strings. In decimal: leading whitespace at both ends of
			// the control range, a mixed sign run with an odd count of minus
			// signs, a stop on a non-digit with digits after it, a space after a
			// sign, and a zero byte after a digit with a sign and a digit behind it.
			if (PLAN[p] == KIND_DECIMAL) begin
				text_q = '{CH_SPACE, CH_WS_LO, CH_WS_HI, CH_MINUS, CH_PLUS, CH_MINUS,
					CH_MINUS, "7", "x", "4"};
				send_string();
				text_q = '{CH_MINUS, CH_SPACE, "5"};
				send_string();
				text_q = '{"5", 8'h00, CH_MINUS, "6"};
				send_string();
			end
			// In hex: the most negative value, which negates onto itself.
			if (PLAN[p] == KIND_HEX) begin
				text_q = '{CH_MINUS, "8"};
				repeat (7) text_q.push_back("0");
				send_string();
			end

			while (chars_sent - phase_start < PHASE_CHARS) begin
				build_string();
				send_string();
			end
			s_tvalid <= 1'b0;
		end

		while (results_seen != strings_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Covered %0d character transactions in %0d strings over %0d alphabet settings.",
			chars_sent, strings_sent, PLAN_LEN);
		$display("Checked %0d results under three idling modes, valid and invalid alphabets.",
			results_seen);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/rsti_pkg.sv
rtl/core/rsti_alpha_check.sv
rtl/core/radix_string_to_integer.sv
rtl/core/rsti_checker.sv
dv/radix_string_to_integer_checker.sv
dv/radix_string_to_integer_test.sv
